FILE: src/itp_pkg.sv
// Shared types, codes and the digit decoder for the integer text parser.
package itp_pkg;

  // Widths of the stream words.
  localparam int unsigned CH_W     = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_USER_W = 1;

  // Mode codes carried in the input tuser.
  localparam logic [1:0] FUNC_AUTO = 2'd0;
  localparam logic [1:0] FUNC_OCT  = 2'd1;
  localparam logic [1:0] FUNC_HEX  = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Characters that the parser looks for.
  localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;

  // Where the parser stands inside a field.
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3
  } phase_t;

  // Number base; automatic means not yet decided.
  typedef enum logic [1:0] {
    RX_DEC  = 2'd0,
    RX_OCT  = 2'd1,
    RX_HEX  = 2'd2,
    RX_AUTO = 2'd3
  } radix_t;

  // Digit decoder: returns {ok, value} for a character in a base.
  function automatic logic [4:0] digit_of(logic [CH_W-1:0] c, radix_t rx);
    logic       ok;
    logic [3:0] d;
    ok = 1'b0;
    d  = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      ok = 1'b1;
      d  = c[3:0];
    end else if (rx == RX_HEX && c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // Both letter cases have the low three bits 1..6 for a..f.
      ok = 1'b1;
      d  = 4'd9 + {1'b0, c[2:0]};
    end
    if (rx == RX_OCT && d[3]) begin
      ok = 1'b0;
    end
    return {ok, d};
  endfunction

endpackage

FILE: src/integer_text_parser.sv
// Stream parser that turns the characters of a text field into a signed 32-bit value.
// Result path: the last character word of a field passes the input register, then the result register.
// Throughput: one character word per cycle; the input register is refilled each cycle
// while the result register is free or being drained, or the held word makes no result.
// Reset: synchronous, active low; clears both valid flags and returns the parser to the
// start of a field.
module integer_text_parser
  import itp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CH_W-1:0]       in_tdata,   // ch
  input  logic [IN_USER_W-1:0]  in_tuser,   // func[1:0], first, field_empty
  input  logic                  in_tlast,   // last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VALUE_W-1:0]    out_tdata,  // value
  output logic [OUT_USER_W-1:0] out_tuser   // status
);

  // Input register.
  logic                 s1_valid_r;
  logic [CH_W-1:0]      s1_ch_r;
  logic [1:0]           s1_func_r;
  logic                 s1_first_r;
  logic                 s1_empty_r;
  logic                 s1_last_r;

  // Field state.
  phase_t               phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  radix_t               radix_r, radix_nxt;
  logic [VALUE_W-1:0]   accum_r, accum_nxt;
  logic                 bad_r, bad_nxt;
  logic                 seen_r, seen_nxt;

  // Result register.
  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_value_r, out_value_nxt;
  logic                 out_status_r, out_status_nxt;

  logic                 has_result;
  logic                 s1_go;
  logic                 in_fire;

  // The word in the input register moves on when it makes no result or the
  // result register can take one.
  assign has_result = s1_empty_r | s1_last_r;
  assign s1_go      = s1_valid_r & (~has_result | ~out_valid_r | out_tready);
  assign in_tready  = ~s1_valid_r | s1_go;
  assign in_fire    = in_tvalid & in_tready;

  // Parse step for the word held in the input register.
  always_comb begin
    logic             body;
    logic             dig;
    logic [4:0]       dcode;
    logic [VALUE_W-1:0] scaled;
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    radix_nxt      = radix_r;
    accum_nxt      = accum_r;
    bad_nxt        = bad_r;
    seen_nxt       = seen_r;
    out_value_nxt  = '0;
    out_status_nxt = STATUS_BAD;
    body           = 1'b0;
    dig            = 1'b0;
    dcode          = '0;
    scaled         = '0;

    if (s1_empty_r) begin
      phase_nxt = PH_START;
      neg_nxt   = 1'b0;
      radix_nxt = RX_DEC;
      accum_nxt = '0;
      bad_nxt   = 1'b0;
      seen_nxt  = 1'b0;
    end else begin
      // Phase handling decides whether this character is a digit.
      if (s1_first_r || phase_r == PH_START) begin
        neg_nxt   = 1'b0;
        accum_nxt = '0;
        bad_nxt   = 1'b0;
        seen_nxt  = 1'b0;
        case (s1_func_r)
          FUNC_OCT: radix_nxt = RX_OCT;
          FUNC_HEX: radix_nxt = RX_HEX;
          default:  radix_nxt = RX_AUTO;
        endcase
        if (s1_ch_r == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGNED;
        end else begin
          body = 1'b1;
        end
      end else if (phase_r == PH_SIGNED) begin
        body = 1'b1;
      end else if (phase_r == PH_ZERO) begin
        phase_nxt = PH_DIGITS;
        if (s1_ch_r == CH_LOWER_X || s1_ch_r == CH_UPPER_X) begin
          radix_nxt = RX_HEX;
          seen_nxt  = 1'b0;
        end else begin
          radix_nxt = RX_OCT;
          dig       = 1'b1;
        end
      end else begin
        dig = 1'b1;
      end

      // First character after an optional sign; a leading zero may be a prefix.
      if (body) begin
        if (radix_nxt == RX_AUTO && s1_ch_r == CH_ZERO) begin
          accum_nxt = '0;
          seen_nxt  = 1'b1;
          phase_nxt = PH_ZERO;
        end else begin
          if (radix_nxt == RX_AUTO) begin
            radix_nxt = RX_DEC;
          end
          phase_nxt = PH_DIGITS;
          dig       = 1'b1;
        end
      end

      // Accumulate one digit: the base multiply is a shift or a shift-add.
      if (dig) begin
        dcode = digit_of(s1_ch_r, radix_nxt);
        case (radix_nxt)
          RX_HEX:  scaled = accum_nxt << 4;
          RX_OCT:  scaled = accum_nxt << 3;
          default: scaled = (accum_nxt << 3) + (accum_nxt << 1);
        endcase
        if (dcode[4]) begin
          accum_nxt = scaled + VALUE_W'(dcode[3:0]);
          seen_nxt  = 1'b1;
        end else begin
          bad_nxt = 1'b1;
        end
      end

      // Close the field on its last character.
      if (s1_last_r) begin
        if (!bad_nxt && seen_nxt) begin
          out_value_nxt  = neg_nxt ? (VALUE_W'(0) - accum_nxt) : accum_nxt;
          out_status_nxt = STATUS_OK;
        end
        phase_nxt = PH_START;
        neg_nxt   = 1'b0;
        radix_nxt = RX_DEC;
        accum_nxt = '0;
        bad_nxt   = 1'b0;
        seen_nxt  = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_START;
      neg_r       <= 1'b0;
      radix_r     <= RX_DEC;
      accum_r     <= '0;
      bad_r       <= 1'b0;
      seen_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        radix_r <= radix_nxt;
        accum_r <= accum_nxt;
        bad_r   <= bad_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r    <= in_tdata;
      s1_func_r  <= in_tuser[1:0];
      s1_first_r <= in_tuser[2];
      s1_empty_r <= in_tuser[3];
      s1_last_r  <= in_tlast;
    end
    if (s1_go && has_result) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

endmodule

FILE: src/itp_checker.sv
// Port-level checks for the integer text parser, bound to its top level.
module itp_checker
  import itp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [VALUE_W-1:0]    out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // Reset leaves no result word pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  // A stalled result word holds its value and status.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // An invalid field always reports zero.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == STATUS_BAD |-> out_tdata == '0)
    else $error("invalid result word carries a nonzero value");

  // An empty field gives an invalid result once the result register is free.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[3]) ##1 (!out_tvalid || out_tready)
    |=> out_tvalid && out_tuser[0] == STATUS_BAD)
    else $error("empty field did not give an invalid result");

endmodule

bind integer_text_parser itp_checker u_itp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: bench/integer_text_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the integer text parser: directed table, then random fields.
module integer_text_parser_tb;
  import itp_pkg::*;

  // Mode code 3 has no name in the package; the parser treats it as automatic.
  localparam logic [1:0] FUNC_SPARE  = 2'd3;
  localparam int unsigned RAND_WORDS = 1200;
  localparam int unsigned DRAIN_CYCLES = 10;

  // One character word as the sender sees it.
  typedef struct packed {
    logic [1:0]      func;
    logic [CH_W-1:0] ch;
    logic            first;
    logic            last;
    logic            no_chars;
  } char_word_t;

  // One parse result word.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } parse_result_t;

  // A directed step, with an optional hand-written result.
  typedef struct packed {
    char_word_t    word;
    logic          fixed;
    parse_result_t fixed_res;
  } table_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CH_W-1:0]       in_tdata = '0;   // ch
  logic [IN_USER_W-1:0]  in_tuser = '0;   // func[1:0], first, field_empty
  logic                  in_tlast = 1'b0; // last
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [VALUE_W-1:0]    out_tdata;       // value
  logic [OUT_USER_W-1:0] out_tuser;       // status

  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 45;
  int unsigned mismatches = 0;

  parse_result_t results_due[$];
  char_word_t    field_words[$];

  // Shadow parser state.
  phase_t             m_phase = PH_START;
  logic               m_neg   = 1'b0;
  radix_t             m_radix = RX_DEC;
  logic [VALUE_W-1:0] m_acc   = '0;
  logic               m_bad   = 1'b0;
  logic               m_digit = 1'b0;

  integer_text_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Back to the start of a field.
  function automatic void clear_parser();
    m_phase = PH_START;
    m_neg   = 1'b0;
    m_radix = RX_DEC;
    m_acc   = '0;
    m_bad   = 1'b0;
    m_digit = 1'b0;
  endfunction

  // Value of a character as a digit of the base, or -1 when it is not one.
  function automatic int digit_value(logic [CH_W-1:0] c, radix_t rx);
    int d;
    d = -1;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (rx == RX_HEX && c >= "a" && c <= "f") begin
      d = c - "a" + 10;
    end else if (rx == RX_HEX && c >= "A" && c <= "F") begin
      d = c - "A" + 10;
    end
    if (rx == RX_OCT && d >= 8) begin
      d = -1;
    end
    return d;
  endfunction

  // Shift one digit into the running value; anything else spoils the field.
  function automatic void absorb_digit(logic [CH_W-1:0] c);
    int d;
    logic [VALUE_W-1:0] base;
    d = digit_value(c, m_radix);
    base = (m_radix == RX_HEX) ? 32'd16 : (m_radix == RX_OCT) ? 32'd8 : 32'd10;
    if (d < 0) begin
      m_bad = 1'b1;
    end else begin
      m_acc   = m_acc * base + VALUE_W'(d);
      m_digit = 1'b1;
    end
  endfunction

  // First character after the optional sign; in automatic mode a zero defers the base.
  function automatic void open_body(logic [CH_W-1:0] c);
    if (m_radix == RX_AUTO) begin
      if (c == CH_ZERO) begin
        m_acc   = '0;
        m_digit = 1'b1;
        m_phase = PH_ZERO;
        return;
      end
      m_radix = RX_DEC;
    end
    m_phase = PH_DIGITS;
    absorb_digit(c);
  endfunction

  // Advance the shadow parser by one accepted word; returns 1 when a result is due.
  function automatic bit parse_char(input char_word_t w, output parse_result_t res);
    res = '0;
    if (w.no_chars) begin
      clear_parser();
      res.status = STATUS_BAD;
      return 1'b1;
    end
    if (w.first || m_phase == PH_START) begin
      m_neg   = 1'b0;
      m_acc   = '0;
      m_bad   = 1'b0;
      m_digit = 1'b0;
      m_radix = (w.func == FUNC_OCT) ? RX_OCT : (w.func == FUNC_HEX) ? RX_HEX : RX_AUTO;
      if (w.ch == CH_MINUS) begin
        m_neg   = 1'b1;
        m_phase = PH_SIGNED;
      end else begin
        open_body(w.ch);
      end
    end else if (m_phase == PH_SIGNED) begin
      open_body(w.ch);
    end else if (m_phase == PH_ZERO) begin
      // An x after the leading zero means hex and needs digits of its own.
      m_phase = PH_DIGITS;
      if (w.ch == CH_LOWER_X || w.ch == CH_UPPER_X) begin
        m_radix = RX_HEX;
        m_digit = 1'b0;
      end else begin
        m_radix = RX_OCT;
        absorb_digit(w.ch);
      end
    end else begin
      absorb_digit(w.ch);
    end
    if (!w.last) begin
      return 1'b0;
    end
    if (m_bad || !m_digit) begin
      res.status = STATUS_BAD;
    end else begin
      res.value  = m_neg ? -m_acc : m_acc;
      res.status = STATUS_OK;
    end
    clear_parser();
    return 1'b1;
  endfunction

  function automatic table_row_t row(logic [1:0] func, logic [CH_W-1:0] ch, logic first,
                                     logic last, logic no_chars, logic fixed,
                                     logic [VALUE_W-1:0] value, logic status);
    table_row_t r;
    r.word.func      = func;
    r.word.ch        = ch;
    r.word.first     = first;
    r.word.last      = last;
    r.word.no_chars  = no_chars;
    r.fixed          = fixed;
    r.fixed_res.value  = value;
    r.fixed_res.status = status;
    return r;
  endfunction

  function automatic logic [CH_W-1:0] oct_char();
    return CH_ZERO + 8'($urandom_range(7));
  endfunction

  function automatic logic [CH_W-1:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) begin
      return CH_ZERO + 8'(v);
    end
    return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(v - 10);
  endfunction

  // Build one random field: mostly well formed, some noise, empty or unterminated fields.
  function automatic void compose_field();
    logic [CH_W-1:0] txt[$];
    logic [1:0]      mode;
    int              n;
    char_word_t      w;
    mode = 2'($urandom_range(3));
    if ($urandom_range(99) < 5) begin
      w.func     = mode;
      w.ch       = 8'($urandom);
      w.first    = 1'($urandom);
      w.last     = 1'($urandom);
      w.no_chars = 1'b1;
      field_words.push_back(w);
      return;
    end
    if ($urandom_range(9) < 3) begin
      txt.push_back(CH_MINUS);
    end
    // Mostly short digit runs; now and then long enough to wrap.
    n = ($urandom_range(4) == 0) ? $urandom_range(12) : $urandom_range(4);
    if (mode == FUNC_OCT) begin
      repeat (n) txt.push_back(oct_char());
    end else if (mode == FUNC_HEX) begin
      repeat (n) txt.push_back(hex_char());
    end else begin
      case ($urandom_range(3))
        0: begin
          txt.push_back(CH_ZERO);
          txt.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
          repeat (n) txt.push_back(hex_char());
        end
        1: begin
          txt.push_back(CH_ZERO);
          repeat (n) txt.push_back(oct_char());
        end
        2: begin
          if (n > 0) begin
            txt.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat (n - 1) txt.push_back(CH_ZERO + 8'($urandom_range(9)));
          end
        end
        default: begin
          txt.push_back(CH_ZERO);
        end
      endcase
    end
    // Noise: overwrite or insert an arbitrary byte.
    if ($urandom_range(99) < 15) begin
      if (txt.size() > 0 && $urandom_range(1)) begin
        txt[$urandom_range(txt.size() - 1)] = 8'($urandom);
      end else begin
        txt.insert($urandom_range(txt.size()), 8'($urandom));
      end
    end
    if (txt.size() == 0) begin
      txt.push_back(8'($urandom));
    end
    foreach (txt[i]) begin
      w.func     = (i == 0) ? mode : 2'($urandom_range(3));
      w.ch       = txt[i];
      w.first    = (i == 0) ? ($urandom_range(9) != 0) : 1'b0;
      w.last     = (i == txt.size() - 1) && ($urandom_range(99) >= 6);
      w.no_chars = 1'b0;
      field_words.push_back(w);
    end
  endfunction

  // Offer one word, with random idle cycles ahead of it, and predict once it is taken.
  task automatic push_word(input char_word_t w, input logic fixed,
                           input parse_result_t fixed_res);
    parse_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w.ch;
    in_tuser  <= {w.no_chars, w.first, w.func};
    in_tlast  <= w.last;
    do @(posedge clk); while (!in_tready);
    if (parse_char(w, res)) begin
      results_due.push_back(fixed ? fixed_res : res);
    end
  endtask

  // Result side: random back-pressure and comparison against the oldest expectation.
  always @(posedge clk) begin
    parse_result_t want;
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word value %h status %b",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_tdata !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    table_row_t  steps[$];
    int unsigned sent;

    // Directed fields; hand-written results where they are obvious.
    steps.push_back(row(FUNC_SPARE, 8'hFF, 1, 1, 1, 1, 0, STATUS_BAD)); // empty field
    steps.push_back(row(FUNC_AUTO, "0", 1, 1, 0, 1, 0, STATUS_OK));     // lone zero
    steps.push_back(row(FUNC_AUTO, "-", 1, 0, 0, 0, 0, STATUS_OK));     // minus zero
    steps.push_back(row(FUNC_AUTO, "0", 0, 1, 0, 1, 0, STATUS_OK));
    steps.push_back(row(FUNC_AUTO, "0", 1, 0, 0, 0, 0, STATUS_OK));     // bare prefix
    steps.push_back(row(FUNC_AUTO, "x", 0, 1, 0, 1, 0, STATUS_BAD));
    steps.push_back(row(FUNC_AUTO, "-", 1, 1, 0, 1, 0, STATUS_BAD));    // lone sign
    steps.push_back(row(FUNC_AUTO, 8'h00, 1, 1, 0, 1, 0, STATUS_BAD));  // lowest byte
    steps.push_back(row(FUNC_OCT, "9", 1, 1, 0, 1, 0, STATUS_BAD));     // bad octal digit
    steps.push_back(row(FUNC_SPARE, "7", 1, 1, 0, 1, 7, STATUS_OK));    // spare mode
    steps.push_back(row(FUNC_AUTO, "5", 0, 1, 0, 1, 5, STATUS_OK));     // no first flag
    steps.push_back(row(FUNC_AUTO, "9", 1, 0, 0, 0, 0, STATUS_OK));     // abandoned field
    steps.push_back(row(FUNC_AUTO, "3", 1, 1, 0, 1, 3, STATUS_OK));
    steps.push_back(row(FUNC_AUTO, "0", 1, 0, 0, 0, 0, STATUS_OK));     // octal 8
    steps.push_back(row(FUNC_AUTO, "8", 0, 1, 0, 1, 0, STATUS_BAD));
    steps.push_back(row(FUNC_HEX, "-", 1, 0, 0, 0, 0, STATUS_OK));      // signed hex
    steps.push_back(row(FUNC_HEX, "f", 0, 0, 0, 0, 0, STATUS_OK));
    steps.push_back(row(FUNC_OCT, "F", 0, 1, 0, 0, 0, STATUS_OK));
    steps.push_back(row(FUNC_AUTO, "0", 1, 0, 0, 0, 0, STATUS_OK));     // automatic hex
    steps.push_back(row(FUNC_HEX, "X", 0, 0, 0, 0, 0, STATUS_OK));
    steps.push_back(row(FUNC_AUTO, "1", 0, 0, 0, 0, 0, STATUS_OK));
    steps.push_back(row(FUNC_AUTO, "a", 0, 1, 0, 0, 0, STATUS_OK));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    clear_parser();

    foreach (steps[i]) begin
      push_word(steps[i].word, steps[i].fixed, steps[i].fixed_res);
    end

    // Random fields in three pressure phases.
    sent = 0;
    while (sent < RAND_WORDS) begin
      if (sent >= 2 * RAND_WORDS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (sent >= RAND_WORDS / 3) begin
        tx_idle_pct = 45;
        rx_idle_pct = 10;
      end
      compose_field();
      while (field_words.size() != 0) begin
        push_word(field_words.pop_front(), 1'b0, '0);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    // Drain and let any stray word show up.
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** integer_text_parser: PASSED **");
    end else begin
      $display("** integer_text_parser: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("** integer_text_parser: FAILED **");
    $finish;
  end

endmodule
